// ===== rtl/abc_pkg.sv =====
// Shared types and constants of the adaptive breakpoint clustering block.
package abc_pkg;

    // Field widths
    localparam int COORD_W    = 20;
    localparam int RANGE_W    = 20;
    localparam int ANGLE_W    = 16;
    localparam int ID_W       = 12;
    localparam int STEP_W     = 15;
    localparam int CONE_W     = 14;
    localparam int SIGMA_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int SINE_W  = 16;  // Q15 sine magnitude, 0..32768
    localparam int PROD_W  = 36;  // min range times sine magnitude
    localparam int QUOT_W  = 22;  // quotient bits kept; larger quotients saturate
    localparam int MAG_W   = 21;  // coordinate difference and threshold magnitude
    localparam int SQ_W    = 42;  // squares and their sum
    localparam int THREE_W = 18;  // three times the noise sigma

    localparam logic [MAG_W-1:0] THR_MAX = 21'd2097151;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_ANGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SIGMA = 2'd2;

    // Configuration reset values
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 15'd182;
    localparam logic [CONE_W-1:0]  CONE_ANGLE_RST  = 14'd8192;
    localparam logic [SIGMA_W-1:0] NOISE_SIGMA_RST = 16'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINE_NUM,
        ST_SINE_DEN,
        ST_SINE_CAP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_THR,
        ST_THR_SQ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic ovf;
    } t_div_status;

endpackage

// ===== rtl/abc_sine_rom.sv =====
// Quarter-wave sine table with angle folding and a registered read port.
module abc_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic [abc_pkg::ANGLE_W-1:0]       i_angle,
    output logic [abc_pkg::SINE_W-1:0]        o_mag
);

    localparam int ENTRIES = 2 ** SINE_TABLE_BITS;
    localparam int IDX_W   = SINE_TABLE_BITS + 1;
    localparam int SHIFT   = 14 - SINE_TABLE_BITS;
    localparam logic [14:0] HALF = 15'((1 << SHIFT) >> 1);
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [abc_pkg::SINE_W-1:0] t_rom [0:ENTRIES];

    // Q30 Taylor series through the x^11 term, rounded to Q15.
    function automatic logic [abc_pkg::SINE_W-1:0] quarter_sine(input logic [14:0] a);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(a) * PI_Q30) >> 15;
        term = x;
        sum  = x;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 6;
        sum  = sum - term;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 20;
        sum  = sum + term;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 42;
        sum  = sum - term;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 72;
        sum  = sum + term;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 110;
        sum  = sum - term;
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[abc_pkg::SINE_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= ENTRIES; i++) begin
            rom[i] = quarter_sine(15'(i << SHIFT));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [14:0]      folded;
    logic [14:0]      idx_full;
    logic [IDX_W-1:0] idx;

    // Mirror odd quadrants, then round to the nearest table entry.
    always_comb begin
        if (i_angle[14]) begin
            folded = 15'(15'd16384 - {1'b0, i_angle[13:0]});
        end else begin
            folded = {1'b0, i_angle[13:0]};
        end
        idx_full = (folded + HALF) >> SHIFT;
        idx = (idx_full > 15'(ENTRIES)) ? IDX_W'(ENTRIES) : idx_full[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_mag <= SINE_ROM[idx];
    end

endmodule

// ===== rtl/abc_serial_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module abc_serial_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [abc_pkg::MAG_W-1:0]     i_a,
    input  logic [abc_pkg::MAG_W-1:0]     i_b,
    output logic                          o_busy,
    output logic [abc_pkg::SQ_W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(abc_pkg::MAG_W + 1);

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [abc_pkg::SQ_W-1:0]   r_mcand;
    logic [abc_pkg::MAG_W-1:0]  r_mplier;
    logic [abc_pkg::SQ_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(abc_pkg::MAG_W);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= abc_pkg::SQ_W'(i_a);
            r_mplier <= i_b;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

// ===== rtl/abc_serial_div.sv =====
// Restoring divider producing one quotient bit per cycle, with overflow detection.
module abc_serial_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [abc_pkg::PROD_W-1:0]    i_dividend,
    input  logic [abc_pkg::SINE_W-1:0]    i_divisor,
    output abc_pkg::t_div_status          o_status,
    output logic [abc_pkg::QUOT_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(abc_pkg::QUOT_W + 1);
    localparam int HI_W  = abc_pkg::PROD_W - abc_pkg::QUOT_W;

    logic                        r_busy;
    logic                        r_ovf;
    logic [CNT_W-1:0]            r_cnt;
    logic [abc_pkg::SINE_W-1:0]  r_rem;
    logic [abc_pkg::SINE_W-1:0]  r_dsr;
    logic [abc_pkg::QUOT_W-1:0]  r_shift;

    logic                        start_ovf;
    logic [abc_pkg::SINE_W:0]    trial;
    logic [abc_pkg::SINE_W:0]    diff;
    logic                        ge;

    // The quotient fits the kept bits exactly when the upper dividend bits
    // are below the divisor; this also keeps the partial remainder narrow.
    assign start_ovf = (abc_pkg::SINE_W'(i_dividend[abc_pkg::PROD_W-1:abc_pkg::QUOT_W])
                        >= i_divisor);
    assign trial = {r_rem, r_shift[abc_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !start_ovf;
            r_ovf  <= start_ovf;
            r_cnt  <= CNT_W'(abc_pkg::QUOT_W);
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= abc_pkg::SINE_W'({{(abc_pkg::SINE_W - HI_W){1'b0}},
                        i_dividend[abc_pkg::PROD_W-1:abc_pkg::QUOT_W]});
            r_dsr   <= i_divisor;
            r_shift <= i_dividend[abc_pkg::QUOT_W-1:0];
        end else if (r_busy) begin
            r_rem   <= ge ? diff[abc_pkg::SINE_W-1:0] : trial[abc_pkg::SINE_W-1:0];
            r_shift <= {r_shift[abc_pkg::QUOT_W-2:0], ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.ovf  = r_ovf;
    assign o_quot        = r_shift;

endmodule

// ===== rtl/adaptive_breakpoint_clustering.sv =====
// Top level of the adaptive breakpoint clustering block for lidar scan points.
//
//   Channel   Direction  Handshake                  Payload
//   point     in         i_valid / o_ready          i_point_x, i_point_y, i_point_range,
//                                                   i_beam_angle, i_first_of_scan
//   label     out        o_valid / i_ready          o_out_x, o_out_y, o_cluster_id,
//                                                   o_starts_cluster
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A point that continues a scan goes through the sine lookups, the product, the 22-step
// bit-serial divider and then the 21-step bit-serial squaring of the threshold before the
// next point can be taken. The first point of a scan, or the first after reset, skips these.
// Reset is synchronous; it restores the configuration registers to their default values
// and forgets the previous point. There is no clearing pass.
// A new point is taken while a finished label still waits in the output register; the
// next label then waits in the final state until the output register is free.
module adaptive_breakpoint_clustering #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int CLUSTER_ID_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Point channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [abc_pkg::COORD_W-1:0]     i_point_x,
    input  logic signed [abc_pkg::COORD_W-1:0]     i_point_y,
    input  logic [abc_pkg::RANGE_W-1:0]            i_point_range,
    input  logic [abc_pkg::ANGLE_W-1:0]            i_beam_angle,
    input  logic                                   i_first_of_scan,
    // Label channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [abc_pkg::COORD_W-1:0]     o_out_x,
    output logic signed [abc_pkg::COORD_W-1:0]     o_out_y,
    output logic [abc_pkg::ID_W-1:0]               o_cluster_id,
    output logic                                   o_starts_cluster,
    // Configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [abc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [abc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam logic [CLUSTER_ID_BITS-1:0] COUNT_MAX = '1;

    // Control state
    abc_pkg::t_state                  r_state;
    abc_pkg::t_state                  n_state;
    logic [abc_pkg::STEP_W-1:0]       r_angle_step;
    logic [abc_pkg::CONE_W-1:0]       r_cone_angle;
    logic [abc_pkg::SIGMA_W-1:0]      r_noise_sigma;
    logic                             r_have_prev;
    logic [CLUSTER_ID_BITS-1:0]       r_count;
    logic [CLUSTER_ID_BITS-1:0]       n_count;
    logic                             r_out_valid;

    // Current point and the previous point of the scan
    logic signed [abc_pkg::COORD_W-1:0] r_px;
    logic signed [abc_pkg::COORD_W-1:0] r_py;
    logic [abc_pkg::RANGE_W-1:0]        r_rng;
    logic [abc_pkg::ANGLE_W-1:0]        r_ang;
    logic                               r_first;
    logic signed [abc_pkg::COORD_W-1:0] r_last_x;
    logic signed [abc_pkg::COORD_W-1:0] r_last_y;
    logic [abc_pkg::RANGE_W-1:0]        r_last_range;
    logic [abc_pkg::ANGLE_W-1:0]        r_last_angle;

    // Working registers
    logic [abc_pkg::SINE_W-1:0]  r_snum;
    logic [abc_pkg::SINE_W-1:0]  r_sden;
    logic [abc_pkg::PROD_W-1:0]  r_prod;
    logic [abc_pkg::SQ_W-1:0]    r_dist2;
    logic                        r_join;

    // Output register
    logic signed [abc_pkg::COORD_W-1:0] r_out_x;
    logic signed [abc_pkg::COORD_W-1:0] r_out_y;
    logic [abc_pkg::ID_W-1:0]           r_out_id;
    logic                               r_out_start;
    logic                               n_start;

    // Sequencer outputs
    logic in_ready;
    logic rom_sel_den;
    logic num_cap;
    logic den_cap;
    logic prod_load;
    logic sq_start;
    logic div_start;
    logic thr_start;
    logic join_load;
    logic out_load;
    logic out_free;

    // Datapath
    logic [abc_pkg::ANGLE_W-1:0]   d16;
    logic [abc_pkg::ANGLE_W-1:0]   den_angle;
    logic [abc_pkg::ANGLE_W-1:0]   rom_angle;
    logic [abc_pkg::ANGLE_W:0]     step_mag;
    logic                          big_step;
    logic                          den_bad;
    logic                          skip;
    logic [abc_pkg::RANGE_W-1:0]   min_range;
    logic [abc_pkg::MAG_W-1:0]     dx;
    logic [abc_pkg::MAG_W-1:0]     dy;
    logic [abc_pkg::MAG_W-1:0]     dx_mag;
    logic [abc_pkg::MAG_W-1:0]     dy_mag;
    logic [abc_pkg::THREE_W-1:0]   three_sigma;
    logic [abc_pkg::QUOT_W:0]      thr_sum;
    logic [abc_pkg::MAG_W-1:0]     thr;
    logic [abc_pkg::MAG_W-1:0]     sqx_a;
    logic                          sqx_start;

    // Unit connections
    logic [abc_pkg::SINE_W-1:0]    rom_mag;
    logic                          sqx_busy;
    logic                          sqy_busy;
    logic [abc_pkg::SQ_W-1:0]      sqx_prod;
    logic [abc_pkg::SQ_W-1:0]      sqy_prod;
    abc_pkg::t_div_status          div_status;
    logic [abc_pkg::QUOT_W-1:0]    div_quot;

    // ------------------------------------------------------------------
    // Angle handling. The previous and current points stay put for the
    // whole item, so these terms are worked out from registers directly.
    // ------------------------------------------------------------------
    always_comb begin
        d16       = r_ang - r_last_angle;
        den_angle = abc_pkg::ANGLE_W'({2'b00, r_cone_angle}) - d16;
        rom_angle = rom_sel_den ? den_angle : d16;
        if (d16[abc_pkg::ANGLE_W-1]) begin
            step_mag = 17'h10000 - {1'b0, d16};
        end else begin
            step_mag = {1'b0, d16};
        end
        // A jump of more than four angular steps breaks the cluster.
        big_step = (step_mag > {r_angle_step, 2'b00});
        // The denominator sine must be strictly positive.
        den_bad  = den_angle[abc_pkg::ANGLE_W-1] || (r_sden == '0);
        skip     = r_first || !r_have_prev;
    end

    // Distance terms: magnitudes of the coordinate differences.
    always_comb begin
        min_range = (r_rng < r_last_range) ? r_rng : r_last_range;
        dx = {r_px[abc_pkg::COORD_W-1], r_px} - {r_last_x[abc_pkg::COORD_W-1], r_last_x};
        dy = {r_py[abc_pkg::COORD_W-1], r_py} - {r_last_y[abc_pkg::COORD_W-1], r_last_y};
        dx_mag = dx[abc_pkg::MAG_W-1] ? (~dx + abc_pkg::MAG_W'(1)) : dx;
        dy_mag = dy[abc_pkg::MAG_W-1] ? (~dy + abc_pkg::MAG_W'(1)) : dy;
    end

    // Threshold: the signed quotient plus three sigma, clamped at zero and saturated so
    // that its square still fits; zero on a big step or a bad denominator. A quotient too
    // large for the divider saturates the threshold when positive and zeroes it when negative.
    always_comb begin
        three_sigma = abc_pkg::THREE_W'({2'b00, r_noise_sigma})
                    + abc_pkg::THREE_W'({1'b0, r_noise_sigma, 1'b0});
        thr_sum = {1'b0, div_quot} + (abc_pkg::QUOT_W + 1)'(three_sigma);
        if (big_step || den_bad) begin
            thr = '0;
        end else if (!d16[abc_pkg::ANGLE_W-1]) begin
            if (div_status.ovf || (thr_sum > (abc_pkg::QUOT_W + 1)'(abc_pkg::THR_MAX))) begin
                thr = abc_pkg::THR_MAX;
            end else begin
                thr = thr_sum[abc_pkg::MAG_W-1:0];
            end
        end else if (div_status.ovf) begin
            thr = '0;
        end else if (abc_pkg::QUOT_W'(three_sigma) > div_quot) begin
            thr = abc_pkg::MAG_W'(abc_pkg::QUOT_W'(three_sigma) - div_quot);
        end else begin
            thr = '0;
        end
    end

    // Label decision for the finished point.
    always_comb begin
        if (skip) begin
            n_count = '0;
            n_start = 1'b1;
        end else if (r_join) begin
            n_count = r_count;
            n_start = 1'b0;
        end else begin
            n_count = (r_count == COUNT_MAX) ? r_count : r_count + CLUSTER_ID_BITS'(1);
            n_start = 1'b1;
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign sqx_start = sq_start || thr_start;
    assign sqx_a     = thr_start ? thr : dx_mag;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            abc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = abc_pkg::ST_SINE_NUM;
                end
            end
            abc_pkg::ST_SINE_NUM: begin
                n_state = skip ? abc_pkg::ST_DONE : abc_pkg::ST_SINE_DEN;
            end
            abc_pkg::ST_SINE_DEN: n_state = abc_pkg::ST_SINE_CAP;
            abc_pkg::ST_SINE_CAP: n_state = abc_pkg::ST_MUL;
            abc_pkg::ST_MUL:      n_state = abc_pkg::ST_DIV_GO;
            abc_pkg::ST_DIV_GO:   n_state = abc_pkg::ST_DIV;
            abc_pkg::ST_DIV: begin
                if (!div_status.busy && !sqx_busy && !sqy_busy) begin
                    n_state = abc_pkg::ST_THR;
                end
            end
            abc_pkg::ST_THR:      n_state = abc_pkg::ST_THR_SQ;
            abc_pkg::ST_THR_SQ: begin
                if (!sqx_busy) begin
                    n_state = abc_pkg::ST_DONE;
                end
            end
            abc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = abc_pkg::ST_IDLE;
                end
            end
            default: n_state = abc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        rom_sel_den = 1'b0;
        num_cap     = 1'b0;
        den_cap     = 1'b0;
        prod_load   = 1'b0;
        sq_start    = 1'b0;
        div_start   = 1'b0;
        thr_start   = 1'b0;
        join_load   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            abc_pkg::ST_IDLE:     in_ready = 1'b1;
            abc_pkg::ST_SINE_NUM: sq_start = !skip;
            abc_pkg::ST_SINE_DEN: begin
                rom_sel_den = 1'b1;
                num_cap     = 1'b1;
            end
            abc_pkg::ST_SINE_CAP: den_cap   = 1'b1;
            abc_pkg::ST_MUL:      prod_load = 1'b1;
            abc_pkg::ST_DIV_GO:   div_start = 1'b1;
            abc_pkg::ST_THR:      thr_start = 1'b1;
            abc_pkg::ST_THR_SQ:   join_load = !sqx_busy;
            abc_pkg::ST_DONE:     out_load  = out_free;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= abc_pkg::ST_IDLE;
            r_angle_step  <= abc_pkg::ANGLE_STEP_RST;
            r_cone_angle  <= abc_pkg::CONE_ANGLE_RST;
            r_noise_sigma <= abc_pkg::NOISE_SIGMA_RST;
            r_have_prev   <= 1'b0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    abc_pkg::CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[abc_pkg::STEP_W-1:0];
                    abc_pkg::CFG_CONE_ANGLE:  r_cone_angle  <= i_cfg_data[abc_pkg::CONE_W-1:0];
                    abc_pkg::CFG_NOISE_SIGMA: r_noise_sigma <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_have_prev <= 1'b1;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_rng   <= i_point_range;
            r_ang   <= i_beam_angle;
            r_first <= i_first_of_scan;
        end
        if (num_cap) begin
            r_snum <= rom_mag;
        end
        if (den_cap) begin
            r_sden <= rom_mag;
        end
        if (prod_load) begin
            r_prod <= {{(abc_pkg::PROD_W - abc_pkg::RANGE_W){1'b0}}, min_range}
                    * {{(abc_pkg::PROD_W - abc_pkg::SINE_W){1'b0}}, r_snum};
        end
        if (thr_start) begin
            r_dist2 <= sqx_prod + sqy_prod;
        end
        if (join_load) begin
            r_join <= (r_dist2 < sqx_prod);
        end
        if (out_load) begin
            r_out_x      <= r_px;
            r_out_y      <= r_py;
            r_out_id     <= abc_pkg::ID_W'(n_count);
            r_out_start  <= n_start;
            r_last_x     <= r_px;
            r_last_y     <= r_py;
            r_last_range <= r_rng;
            r_last_angle <= r_ang;
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------
    abc_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_angle (rom_angle),
        .o_mag   (rom_mag)
    );

    // The x unit squares dx, then squares the threshold.
    abc_serial_mul u_sq_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqx_start),
        .i_a     (sqx_a),
        .i_b     (sqx_a),
        .o_busy  (sqx_busy),
        .o_prod  (sqx_prod)
    );

    abc_serial_mul u_sq_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_a     (dy_mag),
        .i_b     (dy_mag),
        .o_busy  (sqy_busy),
        .o_prod  (sqy_prod)
    );

    abc_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_sden),
        .o_status   (div_status),
        .o_quot     (div_quot)
    );

    assign o_ready          = in_ready;
    assign o_valid          = r_out_valid;
    assign o_out_x          = r_out_x;
    assign o_out_y          = r_out_y;
    assign o_cluster_id     = r_out_id;
    assign o_starts_cluster = r_out_start;
    assign o_cfg_ready      = 1'b1;

endmodule

// ===== rtl/abc_checker.sv =====
// Port-level assertions for the adaptive breakpoint clustering block, with its bind.
module abc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [abc_pkg::COORD_W-1:0]    o_out_x,
    input logic [abc_pkg::COORD_W-1:0]    o_out_y,
    input logic [abc_pkg::ID_W-1:0]       o_cluster_id,
    input logic                           o_starts_cluster
);

    logic                      r_seen;
    logic [abc_pkg::ID_W-1:0]  r_last_id;
    logic                      out_xfer;

    assign out_xfer = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_last_id <= '0;
        end else if (out_xfer) begin
            r_seen    <= 1'b1;
            r_last_id <= o_cluster_id;
        end
    end

    // One point at a time: a point transfer closes the input until it is worked off.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again right after a point transfer");

    // A stalled label holds.
    a_label_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_cluster_id) && $stable(o_starts_cluster))
        else $error("label changed while stalled");

    // The first label after reset has no previous point to join.
    a_first_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !r_seen |-> o_starts_cluster)
        else $error("first label after reset joined a cluster");

    // A point that joins keeps the cluster number of the label before it.
    a_join_keeps_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && !o_starts_cluster |-> o_cluster_id == r_last_id)
        else $error("joined point changed cluster number");

    // A new cluster restarts at zero, advances by one, or stays when saturated.
    a_new_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && o_starts_cluster |->
            o_cluster_id == '0 || o_cluster_id == r_last_id
            || o_cluster_id == abc_pkg::ID_W'(r_last_id + abc_pkg::ID_W'(1)))
        else $error("new cluster number skipped");

endmodule

bind adaptive_breakpoint_clustering abc_checker u_abc_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the adaptive breakpoint clustering block.
module tb_top;
    import abc_pkg::*;

    localparam int SINE_BITS    = 10;
    localparam int SINE_ENTRIES = 1 << SINE_BITS;
    localparam int SINE_SHIFT   = 14 - SINE_BITS;
    localparam int COUNT_MAX    = (1 << ID_W) - 1;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint unsigned THRESH_TOP = 64'd2097151;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RANGE_W-1:0]        range;
        logic [ANGLE_W-1:0]        angle;
        logic                      first;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           id;
        logic                      starts;
    } label_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [COORD_W-1:0] i_point_x = '0;
    logic signed [COORD_W-1:0] i_point_y = '0;
    logic [RANGE_W-1:0] i_point_range = '0;
    logic [ANGLE_W-1:0] i_beam_angle = '0;
    logic i_first_of_scan = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic [ID_W-1:0] o_cluster_id;
    logic o_starts_cluster;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    adaptive_breakpoint_clustering u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_range   (i_point_range),
        .i_beam_angle    (i_beam_angle),
        .i_first_of_scan (i_first_of_scan),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_cluster_id    (o_cluster_id),
        .o_starts_cluster(o_starts_cluster),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the block's registers and previous-point state.
    int unsigned step_cfg  = ANGLE_STEP_RST;
    int unsigned cone_cfg  = CONE_ANGLE_RST;
    int unsigned sigma_cfg = NOISE_SIGMA_RST;
    logic signed [COORD_W-1:0] prev_x = '0;
    logic signed [COORD_W-1:0] prev_y = '0;
    logic [RANGE_W-1:0] prev_range = '0;
    logic [ANGLE_W-1:0] prev_angle = '0;
    int unsigned cluster_num = 0;
    bit have_prev = 1'b0;

    int unsigned sine_rom [0:SINE_ENTRIES];
    label_t pending_labels[$];
    int fails = 0;
    int sender_gap_pct = 0;
    int label_stall_pct = 0;

    // State of the scan generator used by the random test.
    int scan_left = 0;
    int scan_range = 1000;
    logic [ANGLE_W-1:0] scan_angle = '0;

    // Q15 sine of a quarter-turn angle from a Taylor series in Q30.
    function automatic int unsigned quarter_sine(int unsigned a);
        longint unsigned x, term, sum, r;
        x = (longint'(a) * PI_Q30) >> 15;
        term = x;
        sum = x;
        for (int k = 1; k <= 5; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return int'(r);
    endfunction

    function automatic void build_sine_table();
        for (int i = 0; i <= SINE_ENTRIES; i++)
            sine_rom[i] = quarter_sine(i << SINE_SHIFT);
    endfunction

    // Signed Q15 sine of a full-turn binary angle, folded into the first quadrant.
    function automatic int sine_q15(logic [ANGLE_W-1:0] u);
        int unsigned quad, rem, idx;
        quad = u[15:14];
        rem = u[13:0];
        if (quad % 2 == 1)
            rem = 16384 - rem;
        idx = (rem + ((1 << SINE_SHIFT) >> 1)) >> SINE_SHIFT;
        if (idx > SINE_ENTRIES)
            idx = SINE_ENTRIES;
        return (quad >= 2) ? -int'(sine_rom[idx]) : int'(sine_rom[idx]);
    endfunction

    // Breakpoint test against the previous point.
    function automatic bit point_joins(point_t p);
        logic [ANGLE_W-1:0] d16, den_angle;
        int unsigned mag;
        int s_num, s_den;
        longint unsigned minr, quo, three, thr, dist2;
        longint dx, dy;
        d16 = p.angle - prev_angle;
        mag = (d16 >= 16'd32768) ? 65536 - int'(d16) : int'(d16);
        if (mag > 4 * step_cfg)
            return 1'b0;
        s_num = sine_q15(d16);
        den_angle = cone_cfg[15:0] - d16;
        s_den = sine_q15(den_angle);
        if (s_den <= 0)
            return 1'b0;
        minr = (p.range < prev_range) ? p.range : prev_range;
        quo = (minr * longint'(s_num < 0 ? -s_num : s_num)) / longint'(s_den);
        three = 3 * longint'(sigma_cfg);
        if (s_num >= 0)
            thr = quo + three;
        else
            thr = (three > quo) ? three - quo : 64'd0;
        if (thr > THRESH_TOP)
            thr = THRESH_TOP;
        dx = longint'($signed(p.x)) - longint'($signed(prev_x));
        dy = longint'($signed(p.y)) - longint'($signed(prev_y));
        dist2 = dx * dx + dy * dy;
        return dist2 < thr * thr;
    endfunction

    // Label that the block must give this point; advances the mirrored state.
    function automatic label_t predict_label(point_t p);
        label_t lbl;
        bit starts;
        if (p.first || !have_prev) begin
            starts = 1'b1;
            cluster_num = 0;
        end else if (point_joins(p)) begin
            starts = 1'b0;
        end else begin
            starts = 1'b1;
            if (cluster_num < COUNT_MAX)
                cluster_num++;
        end
        prev_x = p.x;
        prev_y = p.y;
        prev_range = p.range;
        prev_angle = p.angle;
        have_prev = 1'b1;
        lbl.x = p.x;
        lbl.y = p.y;
        lbl.id = cluster_num[ID_W-1:0];
        lbl.starts = starts;
        return lbl;
    endfunction

    function automatic point_t make_point(int x, int y, int unsigned r, int unsigned a, bit f);
        point_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.range = r[RANGE_W-1:0];
        p.angle = a[ANGLE_W-1:0];
        p.first = f;
        return p;
    endfunction

    // Mostly realistic scans: points on a sweep at about the scanner resolution, with
    // range jumps at object edges. The rest is raw noise over every field.
    function automatic point_t next_random_point();
        point_t p;
        int unsigned pick;
        int unsigned step;
        longint cx, cy;
        if ($urandom_range(99) < 15) begin
            p = point_t'({$urandom, $urandom, $urandom});
            return p;
        end
        if (scan_left <= 0) begin
            scan_left = $urandom_range(4, 60);
            scan_angle = $urandom;
            scan_range = $urandom_range(300, 30000);
            p.first = 1'b1;
        end else begin
            p.first = 1'b0;
            pick = $urandom_range(99);
            if (pick < 80)
                step = step_cfg + $urandom_range(2) - 1;
            else if (pick < 90)
                step = $urandom;
            else
                step = 65536 - step_cfg;
            scan_angle = scan_angle + step[15:0];
            pick = $urandom_range(99);
            if (pick < 70)
                scan_range = scan_range + int'($urandom_range(200)) - 100;
            else if (pick < 90)
                scan_range = $urandom_range(300, 30000);
            else
                scan_range = $urandom_range(500000);
            if (scan_range < 0)
                scan_range = 0;
        end
        scan_left--;
        cx = (longint'(scan_range) * longint'(sine_q15(scan_angle + 16'd16384))) >>> 15;
        cy = (longint'(scan_range) * longint'(sine_q15(scan_angle))) >>> 15;
        cx = cx + longint'($urandom_range(40)) - 20;
        cy = cy + longint'($urandom_range(40)) - 20;
        p.x = cx[COORD_W-1:0];
        p.y = cy[COORD_W-1:0];
        p.range = scan_range[RANGE_W-1:0];
        p.angle = scan_angle;
        return p;
    endfunction

    function automatic void set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_gap_pct = 0;
                label_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_gap_pct = 84;
                label_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct = 0;
                label_stall_pct = 84;
            end
            default: begin
                sender_gap_pct = 15;
                label_stall_pct = 15;
            end
        endcase
    endfunction

    // Offers one point and returns in the step of its transfer, with valid still high,
    // so that a following point can be offered back to back.
    task automatic send_point(point_t p);
        if ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_gap_pct);
        end
        i_valid <= 1'b1;
        i_point_x <= p.x;
        i_point_y <= p.y;
        i_point_range <= p.range;
        i_beam_angle <= p.angle;
        i_first_of_scan <= p.first;
        do @(posedge i_clk); while (!o_ready);
        pending_labels.push_back(predict_label(p));
    endtask

    // Holds off the sender until every expected label has been taken.
    task automatic drain_labels();
        i_valid <= 1'b0;
        while (pending_labels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ANGLE_STEP:  step_cfg = value & 32'h7FFF;
            CFG_CONE_ANGLE:  cone_cfg = value & 32'h3FFF;
            CFG_NOISE_SIGMA: sigma_cfg = value & 32'hFFFF;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(int unsigned step, int unsigned cone, int unsigned sigma);
        drain_labels();
        cfg_write(CFG_ANGLE_STEP, step);
        cfg_write(CFG_CONE_ANGLE, cone);
        cfg_write(CFG_NOISE_SIGMA, sigma);
    endtask

    // Hand-picked points for the corner cases of the threshold.
    task automatic test_directed_cases();
        set_idling(IDLE_NONE);
        // No previous point after reset, then a near point at the same angle joins.
        send_point(make_point(0, 0, 1000, 0, 0));
        send_point(make_point(10, 10, 1000, 0, 0));
        // Start of scan at the coordinate extremes; the next step wraps through zero
        // and sits exactly on the angle step limit, with a zero range.
        send_point(make_point(-524288, 524287, 1048575, 65535, 1));
        send_point(make_point(524287, -524288, 0, 727, 0));
        // Step just above the limit.
        send_point(make_point(524000, -524000, 5000, 1456, 0));
        // Small negative step: threshold reduced but still positive.
        send_point(make_point(524000, -523950, 5000, 1256, 0));
        // Larger negative step: threshold clamped to zero even for a zero distance.
        send_point(make_point(524000, -523950, 100000, 556, 0));
        // Zero sigma and zero step give a zero threshold.
        load_config(ANGLE_STEP_RST, CONE_ANGLE_RST, 0);
        send_point(make_point(0, 0, 100, 556, 1));
        send_point(make_point(0, 0, 100, 556, 0));
        // Tiny cone: the denominator sine is zero, then negative.
        load_config(16384, 1, 65535);
        send_point(make_point(0, 0, 1000, 0, 1));
        send_point(make_point(0, 0, 1000, 0, 0));
        send_point(make_point(0, 0, 1000, 100, 0));
        // Widest cone with a near-quarter step saturates the threshold.
        load_config(16384, 16383, 65535);
        send_point(make_point(-524288, -524288, 1048575, 0, 1));
        send_point(make_point(524287, 524287, 1048575, 16000, 0));
        // Zero angle step: only an unchanged angle can join.
        load_config(0, CONE_ANGLE_RST, NOISE_SIGMA_RST);
        send_point(make_point(0, 0, 1000, 5, 1));
        send_point(make_point(0, 0, 1000, 5, 0));
        send_point(make_point(0, 0, 1000, 6, 0));
    endtask

    // One long scan where every step is a half turn, so the cluster counter runs
    // into its ceiling and stays there.
    task automatic test_counter_saturation();
        load_config(ANGLE_STEP_RST, CONE_ANGLE_RST, NOISE_SIGMA_RST);
        set_idling(IDLE_NONE);
        send_point(make_point($urandom, $urandom, $urandom, 0, 1));
        for (int i = 1; i < COUNT_MAX + 6; i++)
            send_point(make_point($urandom, $urandom, $urandom, (i % 2) * 32768, 0));
    endtask

    // Random scans over a sweep of register settings and idling patterns.
    task automatic test_random_scans();
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: load_config(ANGLE_STEP_RST, CONE_ANGLE_RST, NOISE_SIGMA_RST);
                1: load_config(1, 1, 0);
                2: load_config(16384, 16383, 65535);
                3: load_config(16384, 1, 300);
                4: load_config(1, 16383, 0);
                default: load_config($urandom_range(1, 2048), $urandom_range(1, 16383),
                                     $urandom_range(0, 2000));
            endcase
            set_idling(idle_mode_t'(k % 4));
            scan_left = 0;
            repeat (206) send_point(next_random_point());
        end
    endtask

    // The label side stalls at random according to the current idling mode.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= label_stall_pct);

    // Every label transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin : label_check
        label_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_labels.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected label: x=%0d y=%0d id=%0d start=%0b",
                             o_out_x, o_out_y, o_cluster_id, o_starts_cluster);
            end else begin
                want = pending_labels.pop_front();
                if (o_out_x !== want.x || o_out_y !== want.y ||
                    o_cluster_id !== want.id || o_starts_cluster !== want.starts) begin
                    fails++;
                    if (fails <= 10)
                        $display("label mismatch: want x=%0d y=%0d id=%0d start=%0b, got x=%0d y=%0d id=%0d start=%0b",
                                 want.x, want.y, want.id, want.starts,
                                 o_out_x, o_out_y, o_cluster_id, o_starts_cluster);
                end
            end
        end
    end

    initial begin
        build_sine_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_counter_saturation();
        test_random_scans();
        drain_labels();
        repeat (60) @(posedge i_clk);
        if (fails == 0 && pending_labels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
